[rtl/core/gsp_pkg.sv]
// Shared widths, types and request structs of the Gauss-Seidel PageRank block.
// Used by gsp_div and gauss_seidel_pagerank; depends on nothing.
`default_nettype none
package gsp_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = $clog2(MAX_NODES);   // node number
    localparam int CNT_W     = IDX_W + 1;           // node count, holds MAX_NODES
    localparam int RANK_W    = 32;                  // rank fraction bits
    localparam int XR_W      = RANK_W + 1;          // stored rank, holds 1.0
    localparam int DIV_W     = 56;                  // divider dividend / quotient
    localparam int DEN_W     = 17;                  // divider divisor
    localparam int TERM_W    = 48;                  // d * x / deg
    localparam int PROD_W    = 50;                  // shared multiplier result
    localparam int SUM_W     = 56;                  // squared-change accumulator

    // input command codes
    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_NODES = 2'd0,
        REG_DAMP  = 2'd1,
        REG_TOL   = 2'd2,
        REG_ITERS = 2'd3
    } t_reg;

    // divider request and response
    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DEN_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

[rtl/core/gsp_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gsp_pkg for widths and the request/response structs.
`default_nettype none
module gsp_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gsp_pkg::t_div_req i_req,
    output gsp_pkg::t_div_rsp      o_rsp
);

    localparam int STEP_W = $clog2(gsp_pkg::DIV_W);

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_W-1:0]           r_cnt;
    logic [gsp_pkg::DIV_W-1:0]   r_num;
    logic [gsp_pkg::DEN_W-1:0]   r_rem;
    logic [gsp_pkg::DEN_W-1:0]   r_den;
    logic [gsp_pkg::DEN_W:0]     n_shift;
    logic [gsp_pkg::DEN_W:0]     n_diff;
    logic                        n_bit;

    // one trial subtract
    always_comb begin
        n_shift = {r_rem, r_num[gsp_pkg::DIV_W-1]};
        n_diff  = n_shift - {1'b0, r_den};
        n_bit   = (n_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_bit ? n_diff[gsp_pkg::DEN_W-1:0] : n_shift[gsp_pkg::DEN_W-1:0];
                r_num <= {r_num[gsp_pkg::DIV_W-2:0], n_bit};
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(gsp_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;

endmodule
`default_nettype wire

[rtl/core/gauss_seidel_pagerank.sv]
// Top level of the Gauss-Seidel PageRank block: graph store, sequencer, output.
// Depends on gsp_pkg and gsp_div.
//
// Usage
//   Slave stream carries commands: add link (source, target), run, clear.
//   An add link request passes through ST_LINK, clear acts in idle, and
//   o_s_tready is low while an add link or a run is in progress. A run fixes
//   dangling nodes, starts the ranks and then runs sweeps. Each node of a
//   sweep is dominated by up to three passes of the shared bit-serial divider
//   (the third only with a self link) plus the neighbor sum over N terms.
//   After the last sweep one result per node leaves on the master stream,
//   node 0 first, tlast on node N-1, each through ST_EMIT_RD and ST_EMIT_LD.
//   A stalled receiver simply holds the block in the emit phase; the current
//   result stays on the port until taken.
//   Reset (synchronous, active low) empties the graph and loads the default
//   registers; the adjacency and out-degree stores clear through valid bits,
//   so no clearing pass is needed. Configuration writes through
//   i_cfg_wr_en / i_cfg_index / i_cfg_data take effect at once and are meant
//   for idle time only.
`default_nettype none
module gauss_seidel_pagerank (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // command stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [1:0] command, [7:2] source_node, [13:8] target_node
    // rank stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [55:0]      o_m_tdata,   // [5:0] node_index, [37:6] rank_value,
                                          // [53:38] sweeps_done, [54] converged
    output logic             o_m_tlast
);

    localparam int N  = gsp_pkg::MAX_NODES;
    localparam int IW = gsp_pkg::IDX_W;
    localparam int CW = gsp_pkg::CNT_W;
    localparam int XW = gsp_pkg::XR_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LINK, ST_FIX_RD, ST_FIX_CHK, ST_FIX_COL,
        ST_BASE, ST_BASE_W, ST_X0, ST_X0_W, ST_INIT_RD, ST_INIT_DEG,
        ST_T_MUL, ST_T_DIV, ST_T_WAIT,
        ST_COL_RD, ST_SUM0, ST_SUM, ST_DEN, ST_DEN_W, ST_XN, ST_XN_W,
        ST_DIFF, ST_SQ, ST_SWEEP_END,
        ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_W
    } t_state;

    // configuration registers
    logic [CW-1:0]  r_cfg_nodes;
    logic [15:0]    r_cfg_damp;
    logic [31:0]    r_cfg_tol;
    logic [15:0]    r_cfg_iters;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nodes <= CW'(64);
            r_cfg_damp  <= 16'd55706;
            r_cfg_tol   <= 32'd2814750;
            r_cfg_iters <= 16'd200;
        end else if (i_cfg_wr_en) begin
            unique case (gsp_pkg::t_reg'(i_cfg_index))
                gsp_pkg::REG_NODES: r_cfg_nodes <= i_cfg_data[CW-1:0];
                gsp_pkg::REG_DAMP:  r_cfg_damp  <= i_cfg_data[15:0];
                gsp_pkg::REG_TOL:   r_cfg_tol   <= i_cfg_data;
                gsp_pkg::REG_ITERS: r_cfg_iters <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // nodes in use, clamped to 1..MAX_NODES
    logic [CW-1:0] n_nodes;
    always_comb begin
        if (r_cfg_nodes == '0)
            n_nodes = CW'(1);
        else if (r_cfg_nodes > CW'(N))
            n_nodes = CW'(N);
        else
            n_nodes = r_cfg_nodes;
    end

    // input fields
    gsp_pkg::t_cmd  n_cmd;
    logic [IW-1:0]  n_src;
    logic [IW-1:0]  n_tgt;
    assign n_cmd = gsp_pkg::t_cmd'(i_s_tdata[1:0]);
    assign n_src = i_s_tdata[7:2];
    assign n_tgt = i_s_tdata[13:8];

    // sequencer registers
    t_state                     r_state;
    logic [CW-1:0]              r_n;
    logic [CW-1:0]              r_i;
    logic [CW-1:0]              r_j;
    logic [IW-1:0]              r_jd;
    logic                       r_pv;
    logic [IW-1:0]              r_src;
    logic [IW-1:0]              r_tgt;
    logic [N-1:0]               r_mask;
    logic [N-1:0]               r_colw;
    logic [15:0]                r_degi;
    logic [48:0]                r_base;
    logic [XW-1:0]              r_x0;
    logic [XW-1:0]              r_x;
    logic [gsp_pkg::SUM_W-1:0]  r_acc;
    logic [gsp_pkg::DEN_W-1:0]  r_den;
    logic [gsp_pkg::PROD_W-1:0] r_prod;
    logic [gsp_pkg::SUM_W-1:0]  r_dsum;
    logic [15:0]                r_iters;
    logic                       r_conv;
    logic                       r_init;

    // memories and their registered read data
    logic [N-1:0]               m_col  [N];   // column i: bit j = link j -> i
    logic [15:0]                m_deg  [N];
    logic [XW-1:0]              m_rank [N];
    logic [gsp_pkg::TERM_W-1:0] m_term [N];
    logic [N-1:0]               r_col_vld;
    logic [N-1:0]               r_deg_vld;
    logic [N-1:0]               r_col_q;
    logic                       r_col_qv;
    logic [15:0]                r_deg_q;
    logic                       r_deg_qv;
    logic [XW-1:0]              r_rank_q;
    logic [gsp_pkg::TERM_W-1:0] r_term_q;

    gsp_pkg::t_div_req n_div_req;
    gsp_pkg::t_div_rsp n_div_rsp;

    gsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (n_div_rsp)
    );

    logic              n_accept;
    logic [IW-1:0]     n_i;
    logic [IW-1:0]     n_deg_raddr;
    logic [15:0]       n_deg_data;
    logic [N-1:0]      n_col_data;
    logic              n_deg_we;
    logic [IW-1:0]     n_deg_waddr;
    logic [15:0]       n_deg_wdata;
    logic              n_col_we;
    logic [IW-1:0]     n_col_addr;
    logic [N-1:0]      n_col_wmask;
    logic              n_rank_we;
    logic [XW-1:0]     n_rank_wdata;
    logic              n_term_we;
    logic [XW-1:0]     n_diff;
    logic [32:0]       n_mul_a;
    logic [24:0]       n_mul_b;
    logic [57:0]       n_mul_p;
    logic [CW-1:0]     n_i_inc;
    logic [15:0]       n_iters_inc;
    logic [15:0]       n_iters_max;
    logic              n_self;

    assign n_accept    = i_s_tvalid && o_s_tready;
    assign n_i         = r_i[IW-1:0];
    assign n_i_inc     = r_i + CW'(1);
    assign n_iters_inc = r_iters + 16'd1;
    assign n_iters_max = (r_cfg_iters == 16'd0) ? 16'd1 : r_cfg_iters;
    assign n_deg_data  = r_deg_qv ? r_deg_q : 16'd0;
    assign n_col_data  = r_col_qv ? r_col_q : '0;
    assign n_self      = r_colw[n_i];
    assign n_diff      = (r_rank_q > r_x) ? (r_rank_q - r_x) : (r_x - r_rank_q);
    assign n_deg_raddr = (r_state == ST_IDLE) ? n_src : n_i;

    // shared multiplier: d * x for terms, the change's top 25 bits squared for the change
    always_comb begin
        if (r_state == ST_DIFF) begin
            n_mul_a = {8'd0, n_diff[32:8]};
            n_mul_b = n_diff[32:8];
        end else begin
            n_mul_a = r_x;
            n_mul_b = {9'd0, r_cfg_damp};
        end
        n_mul_p = n_mul_a * n_mul_b;
    end

    // divider request
    always_comb begin
        n_div_req.start    = 1'b0;
        n_div_req.dividend = '0;
        n_div_req.divisor  = gsp_pkg::DEN_W'(1);
        unique case (r_state)
            ST_BASE: begin
                n_div_req.start    = 1'b1;
                n_div_req.dividend = gsp_pkg::DIV_W'({17'(18'h10000 - {2'd0, r_cfg_damp}),
                                                      32'd0});
                n_div_req.divisor  = gsp_pkg::DEN_W'(r_n);
            end
            ST_X0: begin
                n_div_req.start    = 1'b1;
                n_div_req.dividend = gsp_pkg::DIV_W'(64'h1_0000_0000);
                n_div_req.divisor  = gsp_pkg::DEN_W'(r_n);
            end
            ST_T_DIV: begin
                n_div_req.start    = 1'b1;
                n_div_req.dividend = gsp_pkg::DIV_W'(r_prod);
                n_div_req.divisor  = gsp_pkg::DEN_W'(r_degi);
            end
            ST_DEN: begin
                n_div_req.start    = n_self;
                n_div_req.dividend = gsp_pkg::DIV_W'(r_cfg_damp);
                n_div_req.divisor  = gsp_pkg::DEN_W'(r_degi);
            end
            ST_XN: begin
                n_div_req.start    = 1'b1;
                n_div_req.dividend = r_acc;
                n_div_req.divisor  = r_den;
            end
            default: ;
        endcase
    end

    // memory write controls
    always_comb begin
        n_deg_we     = 1'b0;
        n_deg_waddr  = n_i;
        n_deg_wdata  = 16'(r_n);
        n_col_we     = 1'b0;
        n_col_addr   = n_i;
        n_col_wmask  = r_mask;
        n_rank_we    = 1'b0;
        n_rank_wdata = r_x;
        n_term_we    = (r_state == ST_T_WAIT) && n_div_rsp.done;
        unique case (r_state)
            ST_LINK: begin
                n_deg_we    = 1'b1;
                n_deg_waddr = r_src;
                n_deg_wdata = (n_deg_data == 16'hFFFF) ? 16'hFFFF : n_deg_data + 16'd1;
                n_col_we    = 1'b1;
                n_col_addr  = r_tgt;
                n_col_wmask = N'(1) << r_src;
            end
            ST_FIX_CHK: n_deg_we = (n_deg_data == 16'd0);
            ST_FIX_COL: n_col_we = 1'b1;
            ST_INIT_DEG: begin
                n_rank_we    = 1'b1;
                n_rank_wdata = r_x0;
            end
            ST_DIFF: n_rank_we = 1'b1;
            default: ;
        endcase
    end

    // adjacency columns: masked bit set, or whole word when the column is stale
    always_ff @(posedge i_clk) begin
        if (n_col_we) begin
            if (r_col_vld[n_col_addr]) begin
                for (int b = 0; b < N; b++) begin
                    if (n_col_wmask[b])
                        m_col[n_col_addr][b] <= 1'b1;
                end
            end else begin
                m_col[n_col_addr] <= n_col_wmask;
            end
        end
        r_col_q <= m_col[n_i];
    end

    // out-degree, rank and term stores
    always_ff @(posedge i_clk) begin
        if (n_deg_we)
            m_deg[n_deg_waddr] <= n_deg_wdata;
        r_deg_q <= m_deg[n_deg_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (n_rank_we)
            m_rank[n_i] <= n_rank_wdata;
        r_rank_q <= m_rank[n_i];
    end

    always_ff @(posedge i_clk) begin
        if (n_term_we)
            m_term[n_i] <= n_div_rsp.quotient[gsp_pkg::TERM_W-1:0];
        r_term_q <= m_term[r_j[IW-1:0]];
    end

    // valid bits of the graph stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_vld <= '0;
            r_deg_vld <= '0;
            r_col_qv  <= 1'b0;
            r_deg_qv  <= 1'b0;
        end else begin
            r_col_qv <= r_col_vld[n_i];
            r_deg_qv <= r_deg_vld[n_deg_raddr];
            if (n_accept && n_cmd == gsp_pkg::CMD_CLEAR) begin
                r_col_vld <= '0;
                r_deg_vld <= '0;
            end else begin
                if (n_col_we)
                    r_col_vld[n_col_addr] <= 1'b1;
                if (n_deg_we)
                    r_deg_vld[n_deg_waddr] <= 1'b1;
            end
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            o_m_tvalid <= 1'b0;
            r_pv       <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_src <= n_src;
                    r_tgt <= n_tgt;
                    if (n_accept) begin
                        case (n_cmd)
                            gsp_pkg::CMD_ADD: begin
                                if ({1'b0, n_src} < n_nodes && {1'b0, n_tgt} < n_nodes)
                                    r_state <= ST_LINK;
                            end
                            gsp_pkg::CMD_RUN: begin
                                r_n     <= n_nodes;
                                r_i     <= '0;
                                r_mask  <= '0;
                                r_iters <= '0;
                                r_state <= ST_FIX_RD;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_LINK: r_state <= ST_IDLE;
                ST_FIX_RD: r_state <= ST_FIX_CHK;
                ST_FIX_CHK: begin
                    if (n_deg_data == 16'd0)
                        r_mask[n_i] <= 1'b1;
                    if (n_i_inc == r_n) begin
                        r_i     <= '0;
                        r_state <= ST_FIX_COL;
                    end else begin
                        r_i     <= n_i_inc;
                        r_state <= ST_FIX_RD;
                    end
                end
                ST_FIX_COL: begin
                    if (n_i_inc == r_n) begin
                        r_i     <= '0;
                        r_state <= ST_BASE;
                    end else begin
                        r_i <= n_i_inc;
                    end
                end
                ST_BASE: r_state <= ST_BASE_W;
                ST_BASE_W: begin
                    if (n_div_rsp.done) begin
                        r_base  <= n_div_rsp.quotient[48:0];
                        r_state <= ST_X0;
                    end
                end
                ST_X0: r_state <= ST_X0_W;
                ST_X0_W: begin
                    if (n_div_rsp.done) begin
                        r_x0    <= n_div_rsp.quotient[XW-1:0];
                        r_init  <= 1'b1;
                        r_state <= ST_INIT_RD;
                    end
                end
                ST_INIT_RD: r_state <= ST_INIT_DEG;
                ST_INIT_DEG: begin
                    r_degi  <= n_deg_data;
                    r_x     <= r_x0;
                    r_state <= ST_T_MUL;
                end
                ST_T_MUL: begin
                    r_prod  <= n_mul_p[gsp_pkg::PROD_W-1:0];
                    r_state <= ST_T_DIV;
                end
                ST_T_DIV: r_state <= ST_T_WAIT;
                ST_T_WAIT: begin
                    if (n_div_rsp.done) begin
                        if (n_i_inc == r_n) begin
                            r_i <= '0;
                            if (r_init) begin
                                r_init  <= 1'b0;
                                r_dsum  <= '0;
                                r_state <= ST_COL_RD;
                            end else begin
                                r_state <= ST_SWEEP_END;
                            end
                        end else begin
                            r_i     <= n_i_inc;
                            r_state <= r_init ? ST_INIT_RD : ST_COL_RD;
                        end
                    end
                end
                ST_COL_RD: r_state <= ST_SUM0;
                ST_SUM0: begin
                    r_colw  <= n_col_data;
                    r_degi  <= n_deg_data;
                    r_acc   <= gsp_pkg::SUM_W'(r_base);
                    r_j     <= '0;
                    r_pv    <= 1'b0;
                    r_state <= ST_SUM;
                end
                // neighbor sum, term read in the cycle before its add
                ST_SUM: begin
                    if (r_pv && r_colw[r_jd] && r_jd != n_i)
                        r_acc <= r_acc + gsp_pkg::SUM_W'(r_term_q);
                    if (r_j < r_n) begin
                        r_jd <= r_j[IW-1:0];
                        r_pv <= 1'b1;
                        r_j  <= r_j + CW'(1);
                    end else begin
                        r_pv    <= 1'b0;
                        r_state <= ST_DEN;
                    end
                end
                ST_DEN: begin
                    if (n_self) begin
                        r_state <= ST_DEN_W;
                    end else begin
                        r_den   <= gsp_pkg::DEN_W'(18'h10000);
                        r_state <= ST_XN;
                    end
                end
                ST_DEN_W: begin
                    if (n_div_rsp.done) begin
                        r_den   <= gsp_pkg::DEN_W'(18'h10000)
                                   - n_div_rsp.quotient[gsp_pkg::DEN_W-1:0];
                        r_state <= ST_XN;
                    end
                end
                ST_XN: r_state <= ST_XN_W;
                ST_XN_W: begin
                    if (n_div_rsp.done) begin
                        if (n_div_rsp.quotient[gsp_pkg::DIV_W-1:32] != '0)
                            r_x <= XW'(32'hFFFF_FFFF);
                        else
                            r_x <= XW'(n_div_rsp.quotient[31:0]);
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_prod  <= n_mul_p[gsp_pkg::PROD_W-1:0];
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_dsum  <= r_dsum + gsp_pkg::SUM_W'(r_prod);
                    r_state <= ST_T_MUL;
                end
                ST_SWEEP_END: begin
                    r_iters <= n_iters_inc;
                    r_i     <= '0;
                    if (r_dsum > gsp_pkg::SUM_W'(r_cfg_tol) && n_iters_inc < n_iters_max) begin
                        r_dsum  <= '0;
                        r_state <= ST_COL_RD;
                    end else begin
                        r_conv  <= (r_dsum <= gsp_pkg::SUM_W'(r_cfg_tol));
                        r_state <= ST_EMIT_RD;
                    end
                end
                ST_EMIT_RD: r_state <= ST_EMIT_LD;
                ST_EMIT_LD: begin
                    o_m_tvalid        <= 1'b1;
                    o_m_tdata[5:0]    <= n_i;
                    o_m_tdata[37:6]   <= r_rank_q[32] ? 32'hFFFF_FFFF : r_rank_q[31:0];
                    o_m_tdata[53:38]  <= r_iters;
                    o_m_tdata[54]     <= r_conv;
                    o_m_tdata[55]     <= 1'b0;
                    o_m_tlast         <= (n_i_inc == r_n);
                    r_state           <= ST_EMIT_W;
                end
                ST_EMIT_W: begin
                    if (i_m_tready) begin
                        o_m_tvalid <= 1'b0;
                        if (o_m_tlast) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_i     <= n_i_inc;
                            r_state <= ST_EMIT_RD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

endmodule
`default_nettype wire
